// ----- rtl/dsse_pkg.sv -----
// Shared constants and types for the scale-space extremum detector.
package dsse_pkg;

    // Geometry and sample format
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_DIM     = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_LAYERS  = 3;

    // Counter and coordinate widths
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int COLW_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int ROWW_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int COORD_BITS  = 10;

    // Configuration register widths
    localparam int DIM_BITS      = 11;
    localparam int THR_BITS      = 15;
    localparam int CFG_DATA_BITS = 15;
    localparam int CFG_IDX_BITS  = 2;

    // Magnitude compare width: wide enough for |sample| and for the threshold
    localparam int MAG_BITS = (SAMPLE_BITS + 1 > THR_BITS) ? SAMPLE_BITS + 1 : THR_BITS;

    // Line store word: row r-2 triple in the low half, row r-1 triple in the high half
    localparam int TRIPLE_BITS = NUM_LAYERS * SAMPLE_BITS;
    localparam int LINE_BITS   = 2 * TRIPLE_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAG_THRESH   = 2'd2;

    // Register reset values (threshold: 0.031 in Q1.15, rounded)
    localparam logic [DIM_BITS-1:0] RESET_LINE_WIDTH   = 11'd640;
    localparam logic [DIM_BITS-1:0] RESET_FRAME_HEIGHT = 11'd480;
    localparam logic [THR_BITS-1:0] RESET_MAG_THRESH   = 15'd1016;

    // Layer slots within a triple
    localparam int LAYER_LOWER  = 0;
    localparam int LAYER_CENTRE = 1;
    localparam int LAYER_UPPER  = 2;

    typedef logic [NUM_LAYERS-1:0][SAMPLE_BITS-1:0] t_triple;

endpackage

// ----- rtl/dsse_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module dsse_ram #(
    parameter  int WIDTH     = 8,
    parameter  int DEPTH     = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dog_scale_space_extremum.sv -----
// Top level: 3x3x3 extremum detector over three difference-of-Gaussian layers.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ---------------------------------------
//   cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//   in       in         i_in_valid/o_in_ready     lower/centre/upper layer samples
//   out      out        o_out_valid/i_out_ready   blob column/row/value, is_maximum
//
// One item per clock sustained while no result is held by a stalled output. An item
// passes through the line store read (stage 1) and the window compare (stage 2), and
// lands in the output register when it produces a result.
// The single line store RAM port pair (one read, one write per cycle) sets the rate.
// Synchronous active-low reset clears counters, valid bits and configuration registers; the line
// store is not cleared and needs no clearing pass. A stalled output holds stage 2
// only when that item produces a result; items without a result keep flowing.
module dog_scale_space_extremum (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dsse_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [dsse_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // pixel input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [dsse_pkg::SAMPLE_BITS-1:0] i_lower_layer_sample,
    input  logic signed [dsse_pkg::SAMPLE_BITS-1:0] i_centre_layer_sample,
    input  logic signed [dsse_pkg::SAMPLE_BITS-1:0] i_upper_layer_sample,
    // extremum output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [dsse_pkg::COORD_BITS-1:0]        o_blob_column,
    output logic [dsse_pkg::COORD_BITS-1:0]        o_blob_row,
    output logic signed [dsse_pkg::SAMPLE_BITS-1:0] o_blob_value,
    output logic                                   o_is_maximum
);

    import dsse_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0] r_line_width;
    logic [DIM_BITS-1:0] r_frame_height;
    logic [THR_BITS-1:0] r_mag_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RESET_LINE_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_mag_thr      <= RESET_MAG_THRESH;
        end else if (i_cfg_valid) begin
            // drop writes to indexes beyond the register list
            unique case (i_cfg_index)
                REG_LINE_WIDTH:   r_line_width   <= DIM_BITS'(i_cfg_data);
                REG_FRAME_HEIGHT: r_frame_height <= DIM_BITS'(i_cfg_data);
                REG_MAG_THRESH:   r_mag_thr      <= THR_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Saturate the frame size into its legal range
    logic [COLW_BITS-1:0] width_eff;
    logic [ROWW_BITS-1:0] height_eff;

    always_comb begin
        if (r_line_width > MAX_WIDTH) begin
            width_eff = COLW_BITS'(MAX_WIDTH);
        end else if (r_line_width < MIN_DIM) begin
            width_eff = COLW_BITS'(MIN_DIM);
        end else begin
            width_eff = COLW_BITS'(r_line_width);
        end
        if (r_frame_height > MAX_HEIGHT) begin
            height_eff = ROWW_BITS'(MAX_HEIGHT);
        end else if (r_frame_height < MIN_DIM) begin
            height_eff = ROWW_BITS'(MIN_DIM);
        end else begin
            height_eff = ROWW_BITS'(r_frame_height);
        end
    end

    // ------------------------------------------------------------------
    // Handshake between stages
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_out_valid;
    logic hit, out_free, s2_go, s2_open, s1_go, s1_open, in_acc;

    // Output register is free when empty or being drained this cycle.
    // Stage 2 retires when it has no result, or when the output can take it.
    assign out_free = !r_out_valid || i_out_ready;
    assign s2_go    = r_v2 && (!hit || out_free);
    assign s2_open  = !r_v2 || s2_go;
    assign s1_go    = r_v1 && s2_open;
    assign s1_open  = !r_v1 || s1_go;
    assign in_acc   = i_in_valid && s1_open;

    assign o_in_ready = s1_open;

    // ------------------------------------------------------------------
    // Position counters: wrap at the start of an item too, so that a
    // resize that leaves the counters out of range takes effect at once
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0]  r_col, n_col, cur_col;
    logic [ROW_BITS-1:0]  r_row, n_row, cur_row;
    logic                 col_wrap;
    logic [ROWW_BITS-1:0] row_a, row_inc;
    logic [COLW_BITS-1:0] col_inc;

    always_comb begin
        col_wrap = COLW_BITS'(r_col) >= width_eff;
        cur_col  = col_wrap ? '0 : r_col;
        row_a    = col_wrap ? ROWW_BITS'(r_row) + ROWW_BITS'(1) : ROWW_BITS'(r_row);
        cur_row  = (row_a >= height_eff) ? '0 : ROW_BITS'(row_a);
        col_inc  = COLW_BITS'(cur_col) + COLW_BITS'(1);
        row_inc  = ROWW_BITS'(cur_row) + ROWW_BITS'(1);
        if (col_inc >= width_eff) begin
            n_col = '0;
            n_row = (row_inc >= height_eff) ? '0 : ROW_BITS'(row_inc);
        end else begin
            n_col = COL_BITS'(col_inc);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column holds rows r-2 and r-1.
    // Read at accept, write back when the item leaves stage 1. Two items
    // at the same column are at least three items apart, so the write
    // always lands before the next read of that column; no forwarding.
    // ------------------------------------------------------------------
    t_triple              in_triple;
    t_triple              r_s1;
    logic [COL_BITS-1:0]  r_c1;
    logic [ROW_BITS-1:0]  r_r1;
    logic [LINE_BITS-1:0] ram_rdata, ram_wdata;
    t_triple              line_r2, line_r1;

    assign in_triple = {i_upper_layer_sample, i_centre_layer_sample, i_lower_layer_sample};
    assign line_r2   = ram_rdata[TRIPLE_BITS-1:0];
    assign line_r1   = ram_rdata[LINE_BITS-1:TRIPLE_BITS];
    // age row r-1 into row r-2, store the new samples as row r-1
    assign ram_wdata = {r_s1, line_r1};

    dsse_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_c1),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 and stage 2 registers; the window is stage 2's state
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0] r_c2;
    logic [ROW_BITS-1:0] r_r2;
    t_triple             r_win [3][3];   // [row][column], column 2 newest

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go) begin
                r_v2 <= 1'b1;
            end else if (s2_go) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= in_triple;
            r_c1 <= cur_col;
            r_r1 <= cur_row;
        end
        // shift the window left and insert the new column
        if (s1_go) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= line_r2;
            r_win[1][2] <= line_r1;
            r_win[2][2] <= r_s1;
            r_c2        <= r_c1;
            r_r2        <= r_r1;
        end
    end

    // ------------------------------------------------------------------
    // Extremum test on the window centre: strict compares against its 26
    // neighbours and a magnitude threshold; skip the first two rows and columns, whose
    // window centre lies on the image border
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] ctr;
    logic signed [MAG_BITS-1:0]    ctr_ext;
    logic [MAG_BITS-1:0]           ctr_mag;
    logic                          mag_ok, is_max, is_min, inner;

    always_comb begin
        ctr     = $signed(r_win[1][1][LAYER_CENTRE]);
        ctr_ext = MAG_BITS'(ctr);
        ctr_mag = ctr_ext[MAG_BITS-1] ? MAG_BITS'(-ctr_ext) : MAG_BITS'(ctr_ext);
        mag_ok  = ctr_mag >= MAG_BITS'(r_mag_thr);
        is_max  = 1'b1;
        is_min  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int l = 0; l < NUM_LAYERS; l++) begin
                    if (!(i == 1 && j == 1 && l == LAYER_CENTRE)) begin
                        if (!($signed(r_win[i][j][l]) < ctr)) is_max = 1'b0;
                        if (!($signed(r_win[i][j][l]) > ctr)) is_min = 1'b0;
                    end
                end
            end
        end
        inner = (r_c2 >= COL_BITS'(2)) && (r_r2 >= ROW_BITS'(2));
        hit   = r_v2 && inner && mag_ok && (is_max || is_min);
    end

    // ------------------------------------------------------------------
    // Output register: report the pixel one row up and one column left
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]         r_blob_column, r_blob_row;
    logic signed [SAMPLE_BITS-1:0] r_blob_value;
    logic                          r_is_maximum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && hit) begin
            r_blob_column <= COORD_BITS'(r_c2 - COL_BITS'(1));
            r_blob_row    <= COORD_BITS'(r_r2 - ROW_BITS'(1));
            r_blob_value  <= ctr;
            r_is_maximum  <= is_max;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_blob_column = r_blob_column;
    assign o_blob_row    = r_blob_row;
    assign o_blob_value  = r_blob_value;
    assign o_is_maximum  = r_is_maximum;

endmodule

// ----- rtl/dsse_checker.sv -----
// Port-level checker for the extremum detector, bound to the top level.
module dsse_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_in_ready,
    input logic                                    o_out_valid,
    input logic                                    i_out_ready,
    input logic [dsse_pkg::COORD_BITS-1:0]         o_blob_column,
    input logic [dsse_pkg::COORD_BITS-1:0]         o_blob_row,
    input logic signed [dsse_pkg::SAMPLE_BITS-1:0] o_blob_value,
    input logic                                    o_is_maximum
);

    // Reset empties the output register
    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_blob_column)
            && $stable(o_blob_row) && $stable(o_blob_value) && $stable(o_is_maximum))
        else $error("stalled result changed or dropped");

    // Pixels in the first row or column are never reported
    a_no_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_blob_column != '0) && (o_blob_row != '0))
        else $error("border pixel reported");

    // With the output free, the pipeline never refuses an item
    a_in_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output free");

endmodule

bind dog_scale_space_extremum dsse_checker u_dsse_checker (.*);
